// File: hw/rtl/i2ctrm_pkg.sv
// shared types and constants for the i2c target register map
`default_nettype none

package i2ctrm_pkg;

	localparam int MAP_IDX_W = 8;

	localparam logic [7:0] ID_REG = 8'h0F;
	localparam logic [7:0] ID_VALUE = 8'h6A;
	localparam logic [7:0] CTRL_REG = 8'h10;
	localparam logic [7:0] OUT_BASE = 8'h28;
	localparam logic [2:0] SAMPLE_LAST = 3'd5;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd106;
	localparam logic [15:0] BIAS_RESET = 16'd100;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_ADDRESS = 3'd1,
		CMD_SELECT = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ = 3'd4,
		CMD_STOP = 3'd5,
		CMD_SAMPLE = 3'd6
	} cmd_e;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_START = 3'd1,
		PH_ADDRESS = 3'd2,
		PH_REGISTER = 3'd3,
		PH_READ = 3'd4,
		PH_WRITE = 3'd5
	} phase_e;

	typedef enum logic {
		CFG_DEVICE_ADDRESS = 1'b0,
		CFG_SAMPLE_BIAS = 1'b1
	} cfg_idx_e;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] bus_address;
		logic read_not_write;
		logic [7:0] byte_value;
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] sample_z;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic accepted;
		logic [2:0] phase_now;
		logic sensor_enabled;
	} out_item_t;

	typedef struct packed {
		logic wr_en;
		logic [MAP_IDX_W-1:0] wr_addr;
		logic [7:0] wr_data;
		logic rd_en;
		logic [MAP_IDX_W-1:0] rd_addr;
	} mem_req_t;

	// value an entry holds before it is first written
	function automatic logic [7:0] map_reset_byte(input logic [MAP_IDX_W-1:0] idx);
		logic [7:0] val;
		val = (idx == ID_REG) ? ID_VALUE : 8'h00;
		return val;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/i2ctrm_map_mem.sv
// register map memory with per-entry written bits and registered read
`default_nettype none

module i2ctrm_map_mem import i2ctrm_pkg::*; #(
	parameter int MAP_SIZE = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mem_req_t mem_req,
	output logic [7:0] rd_data
);

	localparam int AW = $clog2(MAP_SIZE);

	logic [7:0] mem_q [MAP_SIZE];
	logic [MAP_SIZE-1:0] written_q;
	logic [7:0] rd_data_q;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;

	assign wr_idx = mem_req.wr_addr[AW-1:0];
	assign rd_idx = mem_req.rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[wr_idx] <= mem_req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (mem_req.wr_en) begin
			written_q[wr_idx] <= 1'b1;
		end
	end

	// unwritten entries read back their reset image
	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data_q <= written_q[rd_idx] ? mem_q[rd_idx] : map_reset_byte(mem_req.rd_addr);
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/i2ctrm_ctrl.sv
// bus phase sequencer, pointer, enable flag and result register
`default_nettype none

module i2ctrm_ctrl import i2ctrm_pkg::*; #(
	parameter int MAP_SIZE = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic [6:0] dev_addr,
	input wire logic [15:0] bias,
	output mem_req_t mem_req,
	input wire logic [7:0] rd_data
);

	localparam logic [MAP_IDX_W:0] MapLimit = (MAP_IDX_W+1)'(MAP_SIZE);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SAMPLE = 4'b0100,
		ST_DONE = 4'b1000
	} state_e;

	state_e state_q, state_d;
	in_item_t item_q;
	logic [2:0] phase_q, phase_d;
	logic [7:0] ptr_q, ptr_d;
	logic en_q, en_d;
	logic [2:0] cnt_q;
	out_item_t res_q, res;
	out_item_t out_data_q;
	logic out_valid_q;

	logic in_fire, out_free, push, ptr_in_range, go_sample, exec_wr;
	logic [15:0] axis, sum;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ptr_in_range = ({1'b0, ptr_q} < MapLimit);

	// command decode against the current phase
	always_comb begin
		phase_d = phase_q;
		ptr_d = ptr_q;
		en_d = en_q;
		go_sample = 1'b0;
		exec_wr = 1'b0;
		res = '0;
		unique case (item_q.command)
			CMD_START: begin
				phase_d = PH_START;
				res.accepted = 1'b1;
			end
			CMD_ADDRESS: begin
				if (phase_q == PH_START) begin
					if (item_q.bus_address == dev_addr) begin
						phase_d = item_q.read_not_write ? PH_READ : PH_REGISTER;
						res.accepted = 1'b1;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			CMD_SELECT: begin
				if (phase_q == PH_REGISTER) begin
					ptr_d = item_q.byte_value;
					phase_d = PH_WRITE;
					res.accepted = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (phase_q == PH_WRITE) begin
					exec_wr = ptr_in_range;
					if (ptr_q == CTRL_REG) begin
						en_d = (item_q.byte_value != 8'h00);
					end
					ptr_d = ptr_q + 8'd1;
					res.accepted = 1'b1;
				end
			end
			CMD_READ: begin
				if (phase_q == PH_READ) begin
					res.read_byte = ptr_in_range ? rd_data : 8'h00;
					ptr_d = ptr_q + 8'd1;
					res.accepted = 1'b1;
				end
			end
			CMD_STOP: begin
				phase_d = PH_IDLE;
				res.accepted = 1'b1;
			end
			CMD_SAMPLE: begin
				if (en_q) begin
					go_sample = 1'b1;
					res.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.phase_now = phase_d;
		res.sensor_enabled = en_d;
	end

	// one output byte per cycle: axis from cnt[2:1], half from cnt[0]
	always_comb begin
		unique case (cnt_q[2:1])
			2'd0: axis = item_q.sample_x;
			2'd1: axis = item_q.sample_y;
			default: axis = item_q.sample_z;
		endcase
		sum = axis + bias;
	end

	always_comb begin
		mem_req = '0;
		mem_req.rd_en = in_fire && (in_data.command == CMD_READ) && ptr_in_range;
		mem_req.rd_addr = ptr_q;
		if (state_q == ST_SAMPLE) begin
			mem_req.wr_en = 1'b1;
			mem_req.wr_addr = OUT_BASE + 8'(cnt_q);
			mem_req.wr_data = cnt_q[0] ? sum[15:8] : sum[7:0];
		end else if (state_q == ST_EXEC) begin
			mem_req.wr_en = exec_wr;
			mem_req.wr_addr = ptr_q;
			mem_req.wr_data = item_q.byte_value;
		end
	end

	always_comb begin
		state_d = state_q;
		push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go_sample) begin
					state_d = ST_SAMPLE;
				end else if (out_free) begin
					push = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SAMPLE: begin
				if (cnt_q == SAMPLE_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			ptr_q <= 8'h00;
			en_q <= 1'b0;
			cnt_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				phase_q <= phase_d;
				ptr_q <= ptr_d;
				en_q <= en_d;
				cnt_q <= 3'd0;
			end else if (state_q == ST_SAMPLE) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
		if (state_q == ST_EXEC) begin
			res_q <= res;
		end
		if (push) begin
			out_data_q <= (state_q == ST_EXEC) ? res : res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> !mem_req.wr_en)
		else $error("map read and write issued together");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_EXEC)
		else $error("accepted word did not enter execute");

	a_phase_address_unused: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_ADDRESS)
		else $error("address phase entered");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SAMPLE |-> cnt_q <= SAMPLE_LAST)
		else $error("sample byte counter overran");

	a_push_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_DONE))
		else $error("result raised outside execute or done");

endmodule

`default_nettype wire

// File: hw/rtl/i2c_target_register_map_unit.sv
// i2c target register map: config registers, sequencer and map memory
// result: pushed from execute, or from done after a sample or while output is held
// flow: a new word is taken only in idle, once the last result is pushed; an enabled
// sample stores its six output bytes through the single map write port, one per cycle
// reset: phase idle, pointer and enable cleared; the map reads its reset image
// through per-entry written bits, so no clearing pass follows reset
`default_nettype none

module i2c_target_register_map_unit import i2ctrm_pkg::*; #(
	parameter int MAP_SIZE = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data
);

	logic [6:0] dev_addr_q;
	logic [15:0] bias_q;
	mem_req_t mem_req;
	logic [7:0] rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
			bias_q <= BIAS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[6:0];
				CFG_SAMPLE_BIAS: bias_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	i2ctrm_ctrl #(
		.MAP_SIZE(MAP_SIZE)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.dev_addr(dev_addr_q),
		.bias(bias_q),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	i2ctrm_map_mem #(
		.MAP_SIZE(MAP_SIZE)
	) u_map_mem (
		.clk(clk),
		.arst_n(arst_n),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire
